// ===== rtl/c2s_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_pkg: shared types and arithmetic for the cartesian to spherical block
// beat payloads, cordic working state, arctangent table and cordic steps
// ----------------------------------------------------------------------------
package c2s_pkg;

    localparam int ATAN_TABLE_LEN = 48;
    localparam int VEC_W          = 36;   // cordic x/y width, holds gain and prerotation
    localparam int ACC_W          = 34;   // cordic angle accumulator width

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } coord_in_t;

    typedef struct packed {
        logic        [31:0] radius;
        logic signed [31:0] azimuth_angle;
        logic        [30:0] zenith_angle;
        logic               at_origin;
    } sph_out_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ACC_W-1:0] acc;
        logic                    hold;
    } cordic_t;

    // atan(2^-i) as a binary angle, 2^31 equals pi
    function automatic logic [29:0] atan_entry(input int unsigned idx);
        logic [29:0] val;
        case (idx)
            0:  val = 30'h20000000;
            1:  val = 30'h12E4051E;
            2:  val = 30'h09FB385B;
            3:  val = 30'h051111D4;
            4:  val = 30'h028B0D43;
            5:  val = 30'h0145D7E1;
            6:  val = 30'h00A2F61E;
            7:  val = 30'h00517C55;
            8:  val = 30'h0028BE53;
            9:  val = 30'h00145F2F;
            10: val = 30'h000A2F98;
            11: val = 30'h000517CC;
            12: val = 30'h00028BE6;
            13: val = 30'h000145F3;
            14: val = 30'h0000A2FA;
            15: val = 30'h0000517D;
            16: val = 30'h000028BE;
            17: val = 30'h0000145F;
            18: val = 30'h00000A30;
            19: val = 30'h00000518;
            20: val = 30'h0000028C;
            21: val = 30'h00000146;
            22: val = 30'h000000A3;
            23: val = 30'h00000051;
            24: val = 30'h00000029;
            25: val = 30'h00000014;
            26: val = 30'h0000000A;
            27: val = 30'h00000005;
            28: val = 30'h00000003;
            29: val = 30'h00000001;
            30: val = 30'h00000001;
            default: val = 30'h0;
        endcase
        return val;
    endfunction

    // quadrant fold ahead of vectoring mode; a zero b operand settles the angle
    function automatic cordic_t cordic_prerotate(input logic signed [VEC_W-1:0] a,
                                                 input logic signed [VEC_W-1:0] b);
        cordic_t c;
        c.vx   = a;
        c.vy   = b;
        c.acc  = '0;
        c.hold = 1'b0;
        if (b == '0) begin
            c.hold = 1'b1;
            c.acc  = a[VEC_W-1] ? ACC_W'(34'sh080000000) : '0;
        end else if (a[VEC_W-1]) begin
            if (!b[VEC_W-1]) begin
                c.vx  = b;
                c.vy  = -a;
                c.acc = ACC_W'(34'sh040000000);
            end else begin
                c.vx  = -b;
                c.vy  = a;
                c.acc = -ACC_W'(34'sh040000000);
            end
        end
        return c;
    endfunction

    // one vectoring iteration, drives vy toward zero
    function automatic cordic_t cordic_step(input cordic_t c, input int unsigned shift);
        cordic_t                 n;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        logic signed [ACC_W-1:0] ang;
        n   = c;
        dx  = c.vy >>> shift;
        dy  = c.vx >>> shift;
        ang = $signed({{(ACC_W-30){1'b0}}, atan_entry(shift)});
        if (!c.hold) begin
            if (c.vy[VEC_W-1]) begin
                n.vx  = c.vx - dx;
                n.vy  = c.vy + dy;
                n.acc = c.acc - ang;
            end else begin
                n.vx  = c.vx + dx;
                n.vy  = c.vy - dy;
                n.acc = c.acc + ang;
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/cartesian_to_spherical.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_spherical: fixed-point point to radius, azimuth and zenith
// fully pipelined squares, bit-serial square roots and twin vectoring cordics
// ----------------------------------------------------------------------------
// One point enters per clock and one result leaves per clock while m_ready
// allows. The pipe runs through the input register, squares, two adder
// stages, 32 square root stages (one root bit each, radius and in-plane norm
// side by side), a quadrant fold stage, one stage per cordic iteration
// (azimuth and zenith side by side) and the output register. The whole pipe
// advances together; it holds only while a finished beat waits on m_ready.
// Radius is floor(sqrt(x^2+y^2+z^2)) in Q16.16, never saturating. Angles are
// binary angles with 2^31 as pi; at or below origin_threshold both are zero
// and at_origin is set. origin_threshold should be written while idle.
module cartesian_to_spherical #(
    parameter int COORD_WIDTH   = 32,
    parameter int CORDIC_STAGES = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  c2s_pkg::coord_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output c2s_pkg::sph_out_t   m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import c2s_pkg::*;

    localparam int EXT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int ITER  = (CORDIC_STAGES < ATAN_TABLE_LEN) ? CORDIC_STAGES
                                                            : ATAN_TABLE_LEN;
    localparam int SQ_STAGES = 32;

    // global pipe advance
    logic en;
    logic m_valid_reg;
    sph_out_t m_data_reg;
    logic [15:0] thr_reg;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // stage 1: sign extend the coordinates, take magnitudes
    logic               v1_reg;
    logic signed [31:0] x1_reg, y1_reg, z1_reg;
    logic        [31:0] ax1_reg, ay1_reg, az1_reg;
    logic signed [31:0] x_ext, y_ext, z_ext;

    assign x_ext = (s_data.coord_x <<< (32 - EXT_W)) >>> (32 - EXT_W);
    assign y_ext = (s_data.coord_y <<< (32 - EXT_W)) >>> (32 - EXT_W);
    assign z_ext = (s_data.coord_z <<< (32 - EXT_W)) >>> (32 - EXT_W);

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg  <= x_ext;
            y1_reg  <= y_ext;
            z1_reg  <= z_ext;
            ax1_reg <= x_ext[31] ? 32'(-x_ext) : 32'(x_ext);
            ay1_reg <= y_ext[31] ? 32'(-y_ext) : 32'(y_ext);
            az1_reg <= z_ext[31] ? 32'(-z_ext) : 32'(z_ext);
        end
    end

    // stage 2: three 32x32 squares
    logic               v2_reg;
    logic signed [31:0] x2_reg, y2_reg, z2_reg;
    logic        [63:0] sx2_reg, sy2_reg, sz2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            z2_reg  <= z1_reg;
            sx2_reg <= ax1_reg * ax1_reg;
            sy2_reg <= ay1_reg * ay1_reg;
            sz2_reg <= az1_reg * az1_reg;
        end
    end

    // stage 3: in-plane sum of squares
    logic               v3_reg;
    logic signed [31:0] x3_reg, y3_reg, z3_reg;
    logic        [63:0] rho2_3_reg, sz3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x3_reg     <= x2_reg;
            y3_reg     <= y2_reg;
            z3_reg     <= z2_reg;
            rho2_3_reg <= sx2_reg + sy2_reg;
            sz3_reg    <= sz2_reg;
        end
    end

    // square root pipe, index 0 loaded by the full sum stage
    logic               sv_reg    [0:SQ_STAGES];
    logic signed [31:0] sx_reg    [0:SQ_STAGES];
    logic signed [31:0] sy_reg    [0:SQ_STAGES];
    logic signed [31:0] sz_reg    [0:SQ_STAGES];
    logic        [63:0] rval_reg  [0:SQ_STAGES];
    logic        [33:0] rrem_reg  [0:SQ_STAGES];
    logic        [31:0] rroot_reg [0:SQ_STAGES];
    logic        [63:0] hval_reg  [0:SQ_STAGES];
    logic        [33:0] hrem_reg  [0:SQ_STAGES];
    logic        [31:0] hroot_reg [0:SQ_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg[0]    <= x3_reg;
            sy_reg[0]    <= y3_reg;
            sz_reg[0]    <= z3_reg;
            rval_reg[0]  <= rho2_3_reg + sz3_reg;
            rrem_reg[0]  <= '0;
            rroot_reg[0] <= '0;
            hval_reg[0]  <= rho2_3_reg;
            hrem_reg[0]  <= '0;
            hroot_reg[0] <= '0;
        end
    end

    // one root bit per stage: bring down two bits, try root*4+1
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        logic [35:0] r_sh, r_try, h_sh, h_try;
        logic        r_fit, h_fit;

        assign r_sh  = {rrem_reg[k], rval_reg[k][63:62]};
        assign r_try = {2'b00, rroot_reg[k], 2'b01};
        assign r_fit = r_sh >= r_try;
        assign h_sh  = {hrem_reg[k], hval_reg[k][63:62]};
        assign h_try = {2'b00, hroot_reg[k], 2'b01};
        assign h_fit = h_sh >= h_try;

        always_ff @(posedge aclk) begin
            if (en) begin
                sx_reg[k+1]    <= sx_reg[k];
                sy_reg[k+1]    <= sy_reg[k];
                sz_reg[k+1]    <= sz_reg[k];
                rval_reg[k+1]  <= {rval_reg[k][61:0], 2'b00};
                rrem_reg[k+1]  <= r_fit ? 34'(r_sh - r_try) : r_sh[33:0];
                rroot_reg[k+1] <= {rroot_reg[k][30:0], r_fit};
                hval_reg[k+1]  <= {hval_reg[k][61:0], 2'b00};
                hrem_reg[k+1]  <= h_fit ? 34'(h_sh - h_try) : h_sh[33:0];
                hroot_reg[k+1] <= {hroot_reg[k][30:0], h_fit};
            end
        end
    end

    // cordic pipe, index 0 loaded by the quadrant fold
    logic        cv_reg   [0:ITER];
    logic [31:0] crad_reg [0:ITER];
    cordic_t     caz_reg  [0:ITER];
    cordic_t     cze_reg  [0:ITER];

    always_ff @(posedge aclk) begin
        if (en) begin
            crad_reg[0] <= rroot_reg[SQ_STAGES];
            caz_reg[0]  <= cordic_prerotate(VEC_W'(sx_reg[SQ_STAGES]),
                                            VEC_W'(sy_reg[SQ_STAGES]));
            // zenith is atan2(rho, z)
            cze_reg[0]  <= cordic_prerotate(VEC_W'(sz_reg[SQ_STAGES]),
                                            $signed({{(VEC_W-32){1'b0}},
                                                     hroot_reg[SQ_STAGES]}));
        end
    end

    for (genvar i = 0; i < ITER; i++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (en) begin
                crad_reg[i+1] <= crad_reg[i];
                caz_reg[i+1]  <= cordic_step(caz_reg[i], i);
                cze_reg[i+1]  <= cordic_step(cze_reg[i], i);
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            sv_reg[0] <= 1'b0;
            cv_reg[0] <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            sv_reg[0] <= v3_reg;
            cv_reg[0] <= sv_reg[SQ_STAGES];
        end
    end

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq_valid
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[k+1] <= 1'b0;
            end else if (en) begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end
    end

    for (genvar i = 0; i < ITER; i++) begin : g_cd_valid
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i+1] <= 1'b0;
            end else if (en) begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end
    end

    // output stage: origin test, wrap azimuth, clamp zenith
    logic                    origin;
    cordic_t                 az_last, ze_last;
    sph_out_t                m_data_next;

    assign az_last = caz_reg[ITER];
    assign ze_last = cze_reg[ITER];
    assign origin  = crad_reg[ITER] <= {16'b0, thr_reg};

    always_comb begin
        m_data_next.radius        = crad_reg[ITER];
        m_data_next.at_origin     = origin;
        m_data_next.azimuth_angle = origin ? '0 : az_last.acc[31:0];
        if (origin || ze_last.acc[ACC_W-1]) begin
            m_data_next.zenith_angle = '0;
        end else if (ze_last.acc[ACC_W-2:31] != '0) begin
            m_data_next.zenith_angle = '1;
        end else begin
            m_data_next.zenith_angle = ze_last.acc[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cv_reg[ITER];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    // checks
    a_origin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.at_origin) |->
            (m_data.azimuth_angle == '0 && m_data.zenith_angle == '0))
        else $error("origin beat carries a nonzero angle");

    a_origin_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && $stable(thr_reg)) |->
            (m_data.at_origin == (m_data.radius <= {16'b0, thr_reg})))
        else $error("origin flag disagrees with radius and threshold");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result beat changed");

endmodule
